// ===== design/lstras_pkg.sv =====
// ----------------------------------------------------------------------------
// lstras_pkg
// Shared types, constants and helpers for the range-add / range-sum tree.
// ----------------------------------------------------------------------------
package lstras_pkg;

  localparam int MOD_W          = 31;
  localparam int SIZE_W         = 11;
  localparam int POS_W          = 10;
  localparam int IN_DATA_W      = 56;   // first, last, amount, zero pad
  localparam int OUT_DATA_W     = 32;   // range_sum, zero pad
  localparam int CFG_ADDR_W     = 1;
  localparam int DEF_MAX_LEAVES = 1024;

  localparam logic [MOD_W-1:0]  MOD_RESET  = 31'h7FFF_FFFF;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE    = 1'b1;

  localparam logic KIND_ADD = 1'b0;

  // walk phase of a tree node frame
  typedef enum logic [1:0] {
    PH_NEW,
    PH_LEFT,
    PH_RIGHT
  } ph_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AMT,
    ST_VISIT,
    ST_POP,
    ST_DONE,
    ST_TG_RD,
    ST_TG_S,
    ST_TG_SW,
    ST_TG_P,
    ST_TG_PW,
    ST_TG_T,
    ST_TG_TW,
    ST_PD_RD,
    ST_PD_M,
    ST_PD_MW,
    ST_PD_R,
    ST_PD_CLR,
    ST_QS_RD,
    ST_QS_M,
    ST_QS_MW,
    ST_RB_RD,
    ST_RB_M,
    ST_RB_MW,
    ST_RB_RD2,
    ST_RB_M2,
    ST_RB_MW2
  } state_t;

  // (a + b) mod m for a, b already below m
  function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_W-1:0];
  endfunction

endpackage

// ===== design/lstras_modred.sv =====
// ----------------------------------------------------------------------------
// lstras_modred
// Bit-serial remainder unit: r = x mod m, one quotient bit per cycle.
// Values already below m finish without the bit-serial pass.
// ----------------------------------------------------------------------------
module lstras_modred #(
  parameter int XW = 42
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [XW-1:0]               x,
  input  logic [lstras_pkg::MOD_W-1:0] m,
  output logic                        done,
  output logic [lstras_pkg::MOD_W-1:0] r
);
  import lstras_pkg::*;

  localparam int CNTW = $clog2(XW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNTW-1:0]  cnt_r;
  logic [XW-1:0]    q_r;
  logic [MOD_W-1:0] rem_r;

  logic [MOD_W:0]   trial;
  logic [MOD_W:0]   trial_sub;
  logic             small_in;

  assign trial     = {rem_r, q_r[XW-1]};
  assign trial_sub = (trial >= {1'b0, m}) ? (trial - {1'b0, m}) : trial;
  assign small_in  = (x < {{(XW-MOD_W){1'b0}}, m});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !small_in;
        done_r <= small_in;
        cnt_r  <= CNTW'(XW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= x;
      rem_r <= small_in ? x[MOD_W-1:0] : '0;
    end else if (busy_r) begin
      q_r   <= {q_r[XW-2:0], 1'b0};
      rem_r <= trial_sub[MOD_W-1:0];
    end
  end

  assign done = done_r;
  assign r    = rem_r;

endmodule

// ===== design/lazy_segment_tree_range_add_sum_mod_unit.sv =====
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum_mod_unit
// Range-add / range-sum store with lazy add tags, kept modulo a modulus.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both node memories to zero, all 2*MAX_LEAVES
// nodes, one node a cycle, with in_tready low. Each item is then handled alone:
// a sequencer walks the tree from the root with a small frame stack, reading,
// reducing and writing back one node memory entry at a time (node sums and
// add tags share an address, registered read). Node values, tags and products
// are reduced in one shared bit-serial remainder unit, which returns a value
// already below the modulus without the bit-serial pass; the product of a tag
// and a span length nearly always takes that pass. An item's time grows with
// the nodes visited and their reductions; an add, which also rebuilds each
// partly covered node, takes longer than a query whose range hits few tag
// pushes. An add of an empty range is taken without leaving idle; an add of
// an amount that reduces to zero ends after that one reduction, with no walk.
// A result waits in the output register while the next item runs; a query
// whose result finds that register still full holds until it is taken.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_add_sum_mod_unit #(
  parameter int MAX_LEAVES = lstras_pkg::DEF_MAX_LEAVES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lstras_pkg::IN_DATA_W-1:0]  in_tdata,   // first, last, amount
  input  logic                              in_tuser,   // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lstras_pkg::OUT_DATA_W-1:0] out_tdata,  // range_sum
  input  logic                              cfg_we,
  input  logic [lstras_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lstras_pkg::MOD_W-1:0]      cfg_wdata
);
  import lstras_pkg::*;

  localparam int LW    = $clog2(MAX_LEAVES);
  localparam int NODES = 2 * MAX_LEAVES;
  localparam int NW    = $clog2(NODES);
  localparam int LENW  = LW + 1;
  localparam int XW    = MOD_W + LENW;
  localparam int CW    = ((LENW > SIZE_W) ? LENW : SIZE_W) + 1;
  localparam int SPW   = $clog2(LW + 1);
  localparam int SIW   = (LW > 1) ? $clog2(LW) : 1;

  typedef struct packed {
    logic [NW-1:0] v;
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
    ph_t           ph;
  } frame_t;

  // input fields
  logic [POS_W-1:0] in_first;
  logic [POS_W-1:0] in_last;
  logic [MOD_W-1:0] in_amount;
  assign in_first  = in_tdata[POS_W-1:0];
  assign in_last   = in_tdata[2*POS_W-1:POS_W];
  assign in_amount = in_tdata[2*POS_W+MOD_W-1:2*POS_W];

  // configuration
  logic [MOD_W-1:0]  modulus_r;
  logic [SIZE_W-1:0] size_r;
  logic [MOD_W-1:0]  m_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
      size_r    <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODULUS: modulus_r <= cfg_wdata;
        REG_SIZE:    size_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_eff = (modulus_r == '0) ? MOD_W'(1) : modulus_r;

  // node memories
  logic [MOD_W-1:0] sums_mem [NODES];
  logic [MOD_W-1:0] tags_mem [NODES];
  logic [MOD_W-1:0] sums_rd_r, tags_rd_r;
  logic [NW-1:0]    rd_addr, wr_addr;
  logic             sums_we, tags_we;
  logic [MOD_W-1:0] sums_wd, tags_wd;

  always_ff @(posedge clk) begin
    if (sums_we) begin
      sums_mem[wr_addr] <= sums_wd;
    end
    if (tags_we) begin
      tags_mem[wr_addr] <= tags_wd;
    end
    sums_rd_r <= sums_mem[rd_addr];
    tags_rd_r <= tags_mem[rd_addr];
  end

  // remainder unit
  logic             md_start, md_done;
  logic [XW-1:0]    md_x;
  logic [MOD_W-1:0] md_r;

  lstras_modred #(.XW(XW)) u_modred (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .x     (md_x),
    .m     (m_eff),
    .done  (md_done),
    .r     (md_r)
  );

  // sequencer state
  state_t           state_r, state_nxt;
  state_t           tg_ret_r, tg_ret_nxt;
  frame_t           cur_r, cur_nxt;
  frame_t           stk [LW];
  logic             stk_we;
  frame_t           stk_wd;
  logic [SPW-1:0]   sp_r, sp_nxt, sp_m1;
  logic [NW-1:0]    clr_r, clr_nxt;
  logic             kind_r, kind_nxt;
  logic [CW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [MOD_W-1:0] t_r, t_nxt, acc_r, acc_nxt, tmp_r, tmp_nxt, tt_r, tt_nxt;
  logic [MOD_W-1:0] tg_t_r, tg_t_nxt, tg_tag_r, tg_tag_nxt;
  logic [NW-1:0]    tg_node_r, tg_node_nxt;
  logic [XW-1:0]    prod_r, prod_nxt;
  logic             out_valid_r, out_load;
  logic [MOD_W-1:0] out_data_r;

  // setup of a tag-node routine
  logic             tg_setup;
  logic [NW-1:0]    setup_node;
  logic [LENW-1:0]  setup_len;
  logic [MOD_W-1:0] setup_t;
  logic [XW-1:0]    setup_prod;
  assign setup_prod = setup_t * setup_len;

  // current node geometry
  logic [LW-1:0]   mid, span;
  logic [LENW-1:0] llen, rlen, cov_len;
  logic [NW-1:0]   lc, rc;
  logic            covered, go_left, go_right;

  assign span     = cur_r.hi - cur_r.lo;
  assign mid      = cur_r.lo + (span >> 1);
  assign llen     = {1'b0, mid} - {1'b0, cur_r.lo} + LENW'(1);
  assign rlen     = {1'b0, cur_r.hi} - {1'b0, mid};
  assign cov_len  = {1'b0, span} + LENW'(1);
  assign lc       = cur_r.v + NW'(1);
  assign rc       = cur_r.v + NW'({llen, 1'b0});
  assign covered  = (a_r <= CW'(cur_r.lo)) && (CW'(cur_r.hi) <= b_r);
  assign go_left  = (a_r <= CW'(mid));
  assign go_right = (b_r > CW'(mid));
  assign sp_m1    = sp_r - 1'b1;

  // range clipping at accept
  logic [CW-1:0] n_use, last_c, first_x;
  logic          nonempty;
  always_comb begin
    n_use   = (CW'(size_r) > CW'(MAX_LEAVES)) ? CW'(MAX_LEAVES) : CW'(size_r);
    first_x = CW'(in_first);
    last_c  = (CW'(in_last) > n_use - 1'b1) ? (n_use - 1'b1) : CW'(in_last);
    nonempty = (n_use != '0) && (first_x <= last_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sp_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    kind_r    <= kind_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    t_r       <= t_nxt;
    acc_r     <= acc_nxt;
    tmp_r     <= tmp_nxt;
    tt_r      <= tt_nxt;
    tg_t_r    <= tg_t_nxt;
    tg_tag_r  <= tg_tag_nxt;
    tg_node_r <= tg_node_nxt;
    tg_ret_r  <= tg_ret_nxt;
    prod_r    <= prod_nxt;
    if (stk_we) begin
      stk[sp_r[SIW-1:0]] <= stk_wd;
    end
    if (out_load) begin
      out_data_r <= acc_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    sp_nxt      = sp_r;
    clr_nxt     = clr_r;
    kind_nxt    = kind_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    t_nxt       = t_r;
    acc_nxt     = acc_r;
    tmp_nxt     = tmp_r;
    tt_nxt      = tt_r;
    tg_t_nxt    = tg_t_r;
    tg_tag_nxt  = tg_tag_r;
    tg_node_nxt = tg_node_r;
    tg_ret_nxt  = tg_ret_r;
    prod_nxt    = prod_r;
    stk_we      = 1'b0;
    stk_wd      = cur_r;
    md_start    = 1'b0;
    md_x        = '0;
    rd_addr     = cur_r.v;
    wr_addr     = cur_r.v;
    sums_we     = 1'b0;
    tags_we     = 1'b0;
    sums_wd     = '0;
    tags_wd     = '0;
    in_tready   = 1'b0;
    out_load    = 1'b0;
    tg_setup    = 1'b0;
    setup_node  = lc;
    setup_len   = llen;
    setup_t     = tt_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_addr = clr_r;
        sums_we = 1'b1;
        tags_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          a_nxt      = first_x;
          b_nxt      = last_c;
          acc_nxt    = '0;
          sp_nxt     = '0;
          cur_nxt.v  = '0;
          cur_nxt.lo = '0;
          cur_nxt.hi = LW'(MAX_LEAVES - 1);
          cur_nxt.ph = PH_NEW;
          if (in_tuser == KIND_ADD) begin
            if (nonempty) begin
              md_start  = 1'b1;
              md_x      = XW'(in_amount);
              state_nxt = ST_AMT;
            end
          end else begin
            state_nxt = nonempty ? ST_VISIT : ST_DONE;
          end
        end
      end
      ST_AMT: begin
        if (md_done) begin
          t_nxt     = md_r;
          state_nxt = (md_r == '0) ? ST_IDLE : ST_VISIT;
        end
      end
      ST_VISIT: begin
        case (cur_r.ph)
          PH_NEW: begin
            if (covered) begin
              if (kind_r == KIND_ADD) begin
                tg_setup   = 1'b1;
                setup_node = cur_r.v;
                setup_len  = cov_len;
                setup_t    = t_r;
                tg_ret_nxt = ST_POP;
                state_nxt  = ST_TG_RD;
              end else begin
                state_nxt = ST_QS_RD;
              end
            end else begin
              state_nxt = ST_PD_RD;
            end
          end
          PH_LEFT: begin
            cur_nxt.ph = PH_RIGHT;
            if (go_right) begin
              stk_we     = 1'b1;
              stk_wd.ph  = PH_RIGHT;
              sp_nxt     = sp_r + 1'b1;
              cur_nxt.v  = rc;
              cur_nxt.lo = mid + 1'b1;
              cur_nxt.hi = cur_r.hi;
              cur_nxt.ph = PH_NEW;
            end
          end
          PH_RIGHT: begin
            state_nxt = (kind_r == KIND_ADD) ? ST_RB_RD : ST_POP;
          end
          default: state_nxt = ST_POP;
        endcase
      end
      ST_POP: begin
        if (sp_r == '0) begin
          state_nxt = (kind_r == KIND_ADD) ? ST_IDLE : ST_DONE;
        end else begin
          cur_nxt   = stk[sp_m1[SIW-1:0]];
          sp_nxt    = sp_m1;
          state_nxt = ST_VISIT;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      // tag one node: sum += t*len, tag += t, all mod m
      ST_TG_RD: begin
        rd_addr   = tg_node_r;
        state_nxt = ST_TG_S;
      end
      ST_TG_S: begin
        md_start   = 1'b1;
        md_x       = XW'(sums_rd_r);
        tg_tag_nxt = tags_rd_r;
        state_nxt  = ST_TG_SW;
      end
      ST_TG_SW: begin
        if (md_done) begin
          tmp_nxt   = md_r;
          state_nxt = ST_TG_P;
        end
      end
      ST_TG_P: begin
        md_start  = 1'b1;
        md_x      = prod_r;
        state_nxt = ST_TG_PW;
      end
      ST_TG_PW: begin
        if (md_done) begin
          tmp_nxt   = add_mod(tmp_r, md_r, m_eff);
          state_nxt = ST_TG_T;
        end
      end
      ST_TG_T: begin
        md_start  = 1'b1;
        md_x      = XW'(tg_tag_r);
        state_nxt = ST_TG_TW;
      end
      ST_TG_TW: begin
        if (md_done) begin
          wr_addr   = tg_node_r;
          sums_we   = 1'b1;
          sums_wd   = tmp_r;
          tags_we   = 1'b1;
          tags_wd   = add_mod(md_r, tg_t_r, m_eff);
          state_nxt = tg_ret_r;
        end
      end
      // push the pending tag of the current node to its children
      ST_PD_RD: begin
        state_nxt = ST_PD_M;
      end
      ST_PD_M: begin
        md_start  = 1'b1;
        md_x      = XW'(tags_rd_r);
        state_nxt = ST_PD_MW;
      end
      ST_PD_MW: begin
        if (md_done) begin
          tt_nxt = md_r;
          if (md_r != '0) begin
            tg_setup   = 1'b1;
            setup_node = lc;
            setup_len  = llen;
            setup_t    = md_r;
            tg_ret_nxt = ST_PD_R;
            state_nxt  = ST_TG_RD;
          end else begin
            state_nxt = ST_PD_CLR;
          end
        end
      end
      ST_PD_R: begin
        tg_setup   = 1'b1;
        setup_node = rc;
        setup_len  = rlen;
        setup_t    = tt_r;
        tg_ret_nxt = ST_PD_CLR;
        state_nxt  = ST_TG_RD;
      end
      ST_PD_CLR: begin
        tags_we    = 1'b1;
        cur_nxt.ph = PH_LEFT;
        if (go_left) begin
          stk_we     = 1'b1;
          stk_wd.ph  = PH_LEFT;
          sp_nxt     = sp_r + 1'b1;
          cur_nxt.v  = lc;
          cur_nxt.lo = cur_r.lo;
          cur_nxt.hi = mid;
          cur_nxt.ph = PH_NEW;
        end
        state_nxt = ST_VISIT;
      end
      // query: fold a covered node into the sum
      ST_QS_RD: begin
        state_nxt = ST_QS_M;
      end
      ST_QS_M: begin
        md_start  = 1'b1;
        md_x      = XW'(sums_rd_r);
        state_nxt = ST_QS_MW;
      end
      ST_QS_MW: begin
        if (md_done) begin
          acc_nxt   = add_mod(acc_r, md_r, m_eff);
          state_nxt = ST_POP;
        end
      end
      // add: rebuild node sum from both children
      ST_RB_RD: begin
        rd_addr   = lc;
        state_nxt = ST_RB_M;
      end
      ST_RB_M: begin
        md_start  = 1'b1;
        md_x      = XW'(sums_rd_r);
        state_nxt = ST_RB_MW;
      end
      ST_RB_MW: begin
        if (md_done) begin
          tmp_nxt   = md_r;
          state_nxt = ST_RB_RD2;
        end
      end
      ST_RB_RD2: begin
        rd_addr   = rc;
        state_nxt = ST_RB_M2;
      end
      ST_RB_M2: begin
        md_start  = 1'b1;
        md_x      = XW'(sums_rd_r);
        state_nxt = ST_RB_MW2;
      end
      ST_RB_MW2: begin
        if (md_done) begin
          sums_we   = 1'b1;
          sums_wd   = add_mod(tmp_r, md_r, m_eff);
          state_nxt = ST_POP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (tg_setup) begin
      tg_node_nxt = setup_node;
      tg_t_nxt    = setup_t;
      prod_nxt    = setup_prod;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == ST_CLEAR)
    else $error("reset did not start the clearing pass");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(LW))
    else $error("frame stack overflow");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(sums_we || tags_we))
    else $error("node memory written while idle");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE) && (sp_r == '0 || !md_start))
    else $error("input taken outside idle");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range-add / range-sum tree unit. A local lazy
// tree predicts each query sum; random items and idling on both streams run
// over several modulus and size settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lstras_pkg::*;

  localparam int LEAVES = DEF_MAX_LEAVES;
  localparam int LIMIT  = 50000000;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    logic [MOD_W-1:0] amount;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [MOD_W-1:0] cfg_wdata = '0;

  lazy_segment_tree_range_add_sum_mod_unit u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [MOD_W-1:0] sums [2*LEAVES];
  logic [MOD_W-1:0] tags [2*LEAVES];
  logic [MOD_W-1:0] pm_modulus;
  logic [SIZE_W-1:0] pm_size;

  item_t pending_items[$];
  logic [MOD_W-1:0] expected_sums[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic void queue_item(item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic longint eff_mod();
    return pm_modulus == 0 ? 1 : longint'(pm_modulus);
  endfunction

  function automatic void tag_node(int v, longint len, longint t, longint m);
    sums[v] = MOD_W'(((longint'(sums[v]) % m) + (t * len) % m) % m);
    tags[v] = MOD_W'(((longint'(tags[v]) % m) + t) % m);
  endfunction

  function automatic void push_tag(int v, int lo, int hi, longint m);
    int mid;
    longint t;
    mid = lo + (hi - lo) / 2;
    t = longint'(tags[v]) % m;
    if (t != 0) begin
      tag_node(v + 1, mid - lo + 1, t, m);
      tag_node(v + 2 * (mid - lo + 1), hi - mid, t, m);
    end
    tags[v] = '0;
  endfunction

  function automatic void tree_add(int v, int lo, int hi, int a, int b, longint t,
                                   longint m);
    int mid, lc, rc;
    if (a <= lo && hi <= b) begin
      tag_node(v, hi - lo + 1, t, m);
      return;
    end
    push_tag(v, lo, hi, m);
    mid = lo + (hi - lo) / 2;
    lc = v + 1;
    rc = v + 2 * (mid - lo + 1);
    if (a <= mid) tree_add(lc, lo, mid, a, b, t, m);
    if (b > mid) tree_add(rc, mid + 1, hi, a, b, t, m);
    sums[v] = MOD_W'(((longint'(sums[lc]) % m) + (longint'(sums[rc]) % m)) % m);
  endfunction

  function automatic longint tree_sum(int v, int lo, int hi, int a, int b, longint m);
    int mid;
    longint acc;
    acc = 0;
    if (a <= lo && hi <= b) return longint'(sums[v]) % m;
    push_tag(v, lo, hi, m);
    mid = lo + (hi - lo) / 2;
    if (a <= mid) acc = (acc + tree_sum(v + 1, lo, mid, a, b, m)) % m;
    if (b > mid) acc = (acc + tree_sum(v + 2 * (mid - lo + 1), mid + 1, hi, a, b, m)) % m;
    return acc;
  endfunction

  function automatic void predict(item_t it);
    longint m, t;
    int n, lst, fst;
    bit nonempty;
    logic [MOD_W-1:0] exp_sum;
    m = eff_mod();
    n = pm_size > LEAVES ? LEAVES : int'(pm_size);
    fst = int'(it.first);
    lst = int'(it.last);
    nonempty = 1'b0;
    if (n != 0) begin
      if (lst > n - 1) lst = n - 1;
      nonempty = fst <= lst;
    end
    if (it.kind == KIND_ADD) begin
      t = longint'(it.amount) % m;
      if (nonempty && t != 0) tree_add(0, 0, LEAVES - 1, fst, lst, t, m);
    end else begin
      exp_sum = nonempty ? MOD_W'(tree_sum(0, 0, LEAVES - 1, fst, lst, m)) : '0;
      expected_sums = {expected_sums, exp_sum};
    end
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
          item_t it;
          it = pending_items.pop_front();
          predict(it);
          in_tvalid <= 1'b1;
          in_tuser <= it.kind;
          in_tdata <= IN_DATA_W'({it.amount, it.last, it.first});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || $urandom_range(99) >= 30;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: sum %0d", out_tdata);
      end else begin
        logic [MOD_W-1:0] exp_sum;
        exp_sum = expected_sums.pop_front();
        if (out_tdata !== OUT_DATA_W'(exp_sum)) begin
          errors++;
          if (errors <= 10) $display("sum mismatch: expected %0d actual %0d", exp_sum,
                                     out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // returns only once the unit is back in idle with nothing pending
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_tvalid || expected_sums.size() > 0 ||
           !in_tready)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [MOD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) pm_modulus = val;
    else pm_size = val[SIZE_W-1:0];
    @(posedge clk);
  endtask

  function automatic item_t rand_item(int n);
    item_t it;
    int a, b;
    it.kind = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      it.first = POS_W'($urandom); it.last = POS_W'($urandom);
    end else begin
      a = $urandom_range(n > 0 ? n - 1 : 0);
      b = $urandom_range(n > 0 ? n - 1 : 0);
      it.first = POS_W'(a < b ? a : b);
      it.last = POS_W'(a < b ? b : a);
      if ($urandom_range(3) == 0)
        it.last = POS_W'(int'(it.first) + int'($urandom_range(3)));
    end
    case ($urandom_range(3))
      0: it.amount = MOD_W'($urandom_range(15));
      1: it.amount = MOD_W'(32'h7FFF_FFFE - $urandom_range(3));
      default: it.amount = MOD_W'($urandom);
    endcase
    return it;
  endfunction

  function automatic item_t mk(logic k, int f, int l, logic [MOD_W-1:0] a);
    item_t it;
    it.kind = k; it.first = POS_W'(f); it.last = POS_W'(l); it.amount = a;
    return it;
  endfunction

  initial begin
    logic [MOD_W-1:0] mods[6];
    int sizes[6];
    for (int i = 0; i < 2 * LEAVES; i++) begin
      sums[i] = '0; tags[i] = '0;
    end
    pm_modulus = MOD_RESET;
    pm_size = SIZE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, empty range, clipping, full range
    queue_item(mk(1'b1, 0, 1023, '0));
    queue_item(mk(1'b0, 0, 1023, 31'h7FFF_FFFE));
    queue_item(mk(1'b1, 0, 1023, '0));
    queue_item(mk(1'b0, 5, 5, 31'h7FFF_FFFF));
    queue_item(mk(1'b0, 1023, 1023, 31'd1));
    queue_item(mk(1'b1, 1023, 1023, 31'h7FFF_FFFF));
    queue_item(mk(1'b0, 10, 3, 31'd77));
    queue_item(mk(1'b1, 10, 3, '0));
    queue_item(mk(1'b0, 100, 612, 31'd12345));
    queue_item(mk(1'b1, 0, 0, '0));
    queue_item(mk(1'b1, 99, 613, '0));
    queue_item(mk(1'b1, 511, 512, '0));
    wait_drained();
    write_reg(REG_SIZE, 31'd300);
    queue_item(mk(1'b0, 250, 1023, 31'd9));
    queue_item(mk(1'b1, 0, 1023, '0));
    queue_item(mk(1'b1, 400, 1023, '0));
    wait_drained();
    write_reg(REG_MODULUS, 31'd0);
    queue_item(mk(1'b0, 0, 20, 31'd5));
    queue_item(mk(1'b1, 0, 20, '0));
    wait_drained();
    write_reg(REG_SIZE, 31'd0);
    queue_item(mk(1'b1, 0, 1023, '0));
    queue_item(mk(1'b0, 0, 1023, 31'd3));
    wait_drained();
    mods = '{31'd1, 31'd7, 31'd1000003, 31'h7FFF_FFFF, 31'h4000_0001, 31'd65536};
    sizes = '{1, 1024, 2047, 37, 512, 1000};
    foreach (mods[p]) begin
      int n;
      write_reg(REG_MODULUS, mods[p]);
      write_reg(REG_SIZE, MOD_W'(sizes[p]));
      n = sizes[p] > LEAVES ? LEAVES : sizes[p];
      calm = (p == 2);
      for (int i = 0; i < 205; i++) queue_item(rand_item(n));
      wait_drained();
    end
    calm = 1'b0;
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
